[hw/rtl/bdws_pkg.sv]
// ----------------------------------------------------------------------------
// bdws_pkg
// Shared types and constants for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdws_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;
    localparam int VALUE_BITS    = 32;
    localparam int OP_BITS       = 3;
    localparam int STATUS_BITS   = 2;
    localparam int FIELD_BITS    = 7;
    localparam int GROUP_BITS    = 8;

    localparam logic [OP_BITS-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_BITS-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_FIND       = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_MISS  = 2'd3;

    localparam logic [FIELD_BITS-1:0] IDX_NONE = 7'h7F;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic cmp;
    } t_cell_ctrl;

endpackage

[hw/rtl/bdws_cell.sv]
// ----------------------------------------------------------------------------
// bdws_cell
// One storage slot of the deque: holds a word, shifts with its neighbors,
// and registers an equality match against the search key.
// ----------------------------------------------------------------------------
module bdws_cell #(
    parameter int WORD_BITS = bdws_pkg::WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  bdws_pkg::t_cell_ctrl  i_ctrl,
    input  logic                  i_load,
    input  logic                  i_live,
    input  logic [WORD_BITS-1:0]  i_word,
    input  logic [WORD_BITS-1:0]  i_left,
    input  logic [WORD_BITS-1:0]  i_right,
    input  logic [WORD_BITS-1:0]  i_key,
    output logic [WORD_BITS-1:0]  o_data,
    output logic                  o_match
);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic                 r_match;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift_up) begin
            n_data = i_left;
        end else if (i_ctrl.shift_down) begin
            n_data = i_right;
        end else if (i_load) begin
            n_data = i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctrl.cmp) begin
            r_match <= i_live && (r_data == i_key);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

[hw/rtl/bounded_deque_with_search_core.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core
// Fixed-depth deque of words in a row of shifting cells, with linear find.
// ----------------------------------------------------------------------------
// Push back, push front, pop back, pop front and unused operation codes are
// handled from the idle state: the row of cells shifts or loads in parallel
// and the result is registered at the same edge. A find passes through a
// compare state, where every cell compares its word with the key and
// registers a match bit, then a scan of the match bits eight positions per
// cycle that stops at the first hit. A new request is taken when the output
// register is empty or its result leaves in the same cycle, and never while a
// find is in progress.
module bounded_deque_with_search_core #(
    parameter int DEPTH     = bdws_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bdws_pkg::WORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [bdws_pkg::OP_BITS-1:0]          i_operation,
    input  logic [bdws_pkg::VALUE_BITS-1:0]       i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [bdws_pkg::STATUS_BITS-1:0]      o_status,
    output logic signed [bdws_pkg::FIELD_BITS-1:0] o_found_index,
    output logic [bdws_pkg::FIELD_BITS-1:0]       o_length
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int GB = bdws_pkg::GROUP_BITS;
    localparam int NG = (DEPTH + GB - 1) / GB;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam int HW = GW + $clog2(GB);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SCAN
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [WORD_BITS-1:0]  r_key, n_key;
    logic [GW-1:0]         r_grp, n_grp;
    logic                  r_o_valid, n_o_valid;
    logic [bdws_pkg::STATUS_BITS-1:0] r_o_status, n_o_status;
    logic [bdws_pkg::FIELD_BITS-1:0]  r_o_idx, n_o_idx;
    logic [bdws_pkg::FIELD_BITS-1:0]  r_o_len, n_o_len;

    logic [WORD_BITS-1:0]  w_word;
    logic [WORD_BITS-1:0]  w_data [DEPTH];
    logic [DEPTH-1:0]      w_match;
    logic [DEPTH-1:0]      w_load;
    logic [NG*GB-1:0]      w_pad;
    logic [GB-1:0]         w_grp_bits;
    logic [$clog2(GB)-1:0] w_pe;
    logic                  w_any;
    logic [HW-1:0]         w_hit_idx;
    logic                  w_out_free;
    logic                  w_acc;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_push_back;
    bdws_pkg::t_cell_ctrl  w_ctrl;

    generate
        if (WORD_BITS <= bdws_pkg::VALUE_BITS) begin : g_word_trunc
            assign w_word = i_value[WORD_BITS-1:0];
        end else begin : g_word_ext
            assign w_word = {{(WORD_BITS - bdws_pkg::VALUE_BITS){1'b0}}, i_value};
        end
    endgenerate

    assign w_out_free = !r_o_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && w_out_free);
    assign w_acc      = i_valid && !o_stall;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [WORD_BITS-1:0] w_left;
            logic [WORD_BITS-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = w_word;
            end else begin : g_mid_l
                assign w_left = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_right = w_data[gi];
            end else begin : g_mid_r
                assign w_right = w_data[gi+1];
            end
            assign w_load[gi] = w_push_back && (r_count == CW'(gi));

            bdws_cell #(
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_load  (w_load[gi]),
                .i_live  (r_count > CW'(gi)),
                .i_word  (w_word),
                .i_left  (w_left),
                .i_right (w_right),
                .i_key   (r_key),
                .o_data  (w_data[gi]),
                .o_match (w_match[gi])
            );
        end
    endgenerate

    // match scan, one group per cycle
    always_comb begin
        w_pad = '0;
        w_pad[DEPTH-1:0] = w_match;
        w_grp_bits = w_pad[r_grp*GB +: GB];
        w_pe = '0;
        for (int k = GB - 1; k >= 0; k--) begin
            if (w_grp_bits[k]) begin
                w_pe = k[$clog2(GB)-1:0];
            end
        end
        w_any = |w_grp_bits;
        w_hit_idx = {r_grp, w_pe};
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_key       = r_key;
        n_grp       = r_grp;
        n_o_valid   = r_o_valid;
        n_o_status  = r_o_status;
        n_o_idx     = r_o_idx;
        n_o_len     = r_o_len;
        w_ctrl      = '0;
        w_push_back = 1'b0;
        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_o_status = bdws_pkg::ST_OK;
                    case (i_operation)
                        bdws_pkg::OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_o_status = bdws_pkg::ST_FULL;
                            end else begin
                                w_push_back = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        bdws_pkg::OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_o_status = bdws_pkg::ST_FULL;
                            end else begin
                                w_ctrl.shift_up = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        bdws_pkg::OP_POP_BACK: begin
                            if (w_empty) begin
                                n_o_status = bdws_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        bdws_pkg::OP_POP_FRONT: begin
                            if (w_empty) begin
                                n_o_status = bdws_pkg::ST_EMPTY;
                            end else begin
                                w_ctrl.shift_down = 1'b1;
                                n_count = r_count - 1'b1;
                            end
                        end
                        bdws_pkg::OP_FIND: begin
                            n_key   = w_word;
                            n_state = S_CMP;
                        end
                        default: begin
                        end
                    endcase
                    if (i_operation != bdws_pkg::OP_FIND) begin
                        n_o_valid = 1'b1;
                        n_o_idx   = bdws_pkg::IDX_NONE;
                        n_o_len   = bdws_pkg::FIELD_BITS'(n_count);
                    end
                end
            end
            S_CMP: begin
                w_ctrl.cmp = 1'b1;
                n_grp      = '0;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (w_any || (r_grp == GW'(NG - 1))) begin
                    if (w_out_free) begin
                        n_o_valid = 1'b1;
                        n_o_len   = bdws_pkg::FIELD_BITS'(r_count);
                        if (w_any) begin
                            n_o_status = bdws_pkg::ST_OK;
                            n_o_idx    = bdws_pkg::FIELD_BITS'(w_hit_idx);
                        end else begin
                            n_o_status = bdws_pkg::ST_MISS;
                            n_o_idx    = bdws_pkg::IDX_NONE;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    n_grp = r_grp + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_key      <= n_key;
        r_grp      <= n_grp;
        r_o_status <= n_o_status;
        r_o_idx    <= n_o_idx;
        r_o_len    <= n_o_len;
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_found_index = r_o_idx;
    assign o_length      = r_o_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("request taken during a find");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_operation != bdws_pkg::OP_FIND)) |=> o_valid)
        else $error("single-cycle request produced no result");

endmodule

[bench/tb_bounded_deque_with_search_core.sv]
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search_core
// Self-checking bench for the bounded deque with linear find. A behavioral
// deque tracks every accepted request and queues the status, found index and
// length it must produce. Results are compared in order. Directed tests cover
// the empty and full corners, every operation and the spare codes. Random
// traffic then swings the length up and down in grow, shrink and mixed phases
// while both handshake sides pause at random.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search_core;

    localparam int DEPTH      = bdws_pkg::DEPTH_DEF;
    localparam int WORD_BITS  = bdws_pkg::WORD_BITS_DEF;
    localparam int CLK_PERIOD = 12;
    localparam int RANDOM_REQUESTS = 640;

    localparam logic [bdws_pkg::OP_BITS-1:0] OP_SPARE_A = 3'd5;
    localparam logic [bdws_pkg::OP_BITS-1:0] OP_SPARE_B = 3'd6;
    localparam logic [bdws_pkg::OP_BITS-1:0] OP_SPARE_C = 3'd7;

    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} t_traffic_mode;

    typedef struct packed {
        logic [bdws_pkg::STATUS_BITS-1:0]       status;
        logic signed [bdws_pkg::FIELD_BITS-1:0] found_index;
        logic [bdws_pkg::FIELD_BITS-1:0]        length;
    } t_deque_result;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_valid;
    logic                                   o_stall;
    logic [bdws_pkg::OP_BITS-1:0]           i_operation;
    logic [bdws_pkg::VALUE_BITS-1:0]        i_value;
    logic                                   o_valid;
    logic                                   i_stall;
    logic [bdws_pkg::STATUS_BITS-1:0]       o_status;
    logic signed [bdws_pkg::FIELD_BITS-1:0] o_found_index;
    logic [bdws_pkg::FIELD_BITS-1:0]        o_length;

    logic [WORD_BITS-1:0] model_words [DEPTH];
    int                   model_len;
    t_deque_result        expected_results[$];
    logic [bdws_pkg::VALUE_BITS-1:0] value_pool [8];

    int fail_count;
    int results_seen;
    int requests_sent;
    int find_hits;
    int find_misses;
    int full_rejects;
    int empty_rejects;
    int spare_ops;

    bit sender_quiet;
    bit sink_quiet;
    int sink_mode_left;
    int stall_left;

    bounded_deque_with_search_core #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_length      (o_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", results_seen, what);
        fail_count++;
    endtask

    // behavioral deque: applies one request and queues its result
    task automatic predict_result(input logic [bdws_pkg::OP_BITS-1:0] op,
                                  input logic [bdws_pkg::VALUE_BITS-1:0] val);
        t_deque_result r;
        int k;
        bit hit;
        r.status      = bdws_pkg::ST_OK;
        r.found_index = bdws_pkg::IDX_NONE;
        hit           = 1'b0;
        case (op)
            bdws_pkg::OP_PUSH_BACK: begin
                if (model_len >= DEPTH) begin
                    r.status = bdws_pkg::ST_FULL;
                    full_rejects++;
                end else begin
                    model_words[model_len] = val[WORD_BITS-1:0];
                    model_len++;
                end
            end
            bdws_pkg::OP_PUSH_FRONT: begin
                if (model_len >= DEPTH) begin
                    r.status = bdws_pkg::ST_FULL;
                    full_rejects++;
                end else begin
                    for (k = model_len; k > 0; k--)
                        model_words[k] = model_words[k-1];
                    model_words[0] = val[WORD_BITS-1:0];
                    model_len++;
                end
            end
            bdws_pkg::OP_POP_BACK: begin
                if (model_len == 0) begin
                    r.status = bdws_pkg::ST_EMPTY;
                    empty_rejects++;
                end else begin
                    model_words[model_len-1] = '0;
                    model_len--;
                end
            end
            bdws_pkg::OP_POP_FRONT: begin
                if (model_len == 0) begin
                    r.status = bdws_pkg::ST_EMPTY;
                    empty_rejects++;
                end else begin
                    for (k = 0; k + 1 < model_len; k++)
                        model_words[k] = model_words[k+1];
                    model_words[model_len-1] = '0;
                    model_len--;
                end
            end
            bdws_pkg::OP_FIND: begin
                r.status = bdws_pkg::ST_MISS;
                for (k = 0; k < model_len; k++) begin
                    if (!hit && model_words[k] == val[WORD_BITS-1:0]) begin
                        hit           = 1'b1;
                        r.status      = bdws_pkg::ST_OK;
                        r.found_index = k[bdws_pkg::FIELD_BITS-1:0];
                    end
                end
                if (hit)
                    find_hits++;
                else
                    find_misses++;
            end
            default: spare_ops++;
        endcase
        r.length = model_len[bdws_pkg::FIELD_BITS-1:0];
        expected_results.push_back(r);
    endtask

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input logic [bdws_pkg::OP_BITS-1:0] op,
                                input logic [bdws_pkg::VALUE_BITS-1:0] val);
        int gap;
        gap = sender_quiet ? 0 : gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_result(op, val);
        requests_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // pick a word that is stored right now, or a pool word when empty
    function automatic logic [bdws_pkg::VALUE_BITS-1:0] stored_word();
        if (model_len == 0)
            return value_pool[$urandom_range(0, 7)];
        return model_words[$urandom_range(0, model_len - 1)];
    endfunction

    always @(posedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode_left = $urandom_range(50, 300);
            sink_quiet     = ($urandom_range(0, 2) == 0);
        end else begin
            sink_mode_left--;
        end
        if (stall_left == 0 && !sink_quiet && $urandom_range(0, 2) == 0)
            stall_left = gap_length();
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_deque_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d index %0d length %0d",
                                          o_status, o_found_index, o_length));
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, exp_r.status));
                if (o_found_index !== exp_r.found_index)
                    report_mismatch($sformatf("found_index %0d, expected %0d",
                                              o_found_index, exp_r.found_index));
                if (o_length !== exp_r.length)
                    report_mismatch($sformatf("length %0d, expected %0d",
                                              o_length, exp_r.length));
            end
            results_seen++;
        end
    end

    task automatic test_empty_list();
        send_request(bdws_pkg::OP_POP_BACK, 32'h0000_0000);
        send_request(bdws_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
        send_request(bdws_pkg::OP_FIND, 32'h0000_0000);
        send_request(bdws_pkg::OP_FIND, 32'hFFFF_FFFF);
        send_request(OP_SPARE_A, 32'hA5A5_A5A5);
        send_request(OP_SPARE_B, 32'h5A5A_5A5A);
        send_request(OP_SPARE_C, 32'hFFFF_FFFF);
    endtask

    task automatic test_basic_operations();
        send_request(bdws_pkg::OP_PUSH_BACK, 32'h0000_0000);
        send_request(bdws_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(bdws_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A);
        send_request(bdws_pkg::OP_PUSH_BACK, 32'h0000_0000);
        send_request(bdws_pkg::OP_FIND, 32'h0000_0000);
        send_request(bdws_pkg::OP_FIND, 32'hFFFF_FFFF);
        send_request(bdws_pkg::OP_FIND, 32'h5A5A_5A5A);
        send_request(bdws_pkg::OP_FIND, 32'h1234_5678);
        send_request(OP_SPARE_C, 32'h0000_0000);
        send_request(bdws_pkg::OP_POP_FRONT, 32'h0000_0000);
        send_request(bdws_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
        send_request(bdws_pkg::OP_FIND, 32'h0000_0000);
        send_request(bdws_pkg::OP_POP_BACK, 32'h0000_0000);
        send_request(bdws_pkg::OP_POP_FRONT, 32'h0000_0000);
        send_request(bdws_pkg::OP_POP_FRONT, 32'h0000_0000);
    endtask

    task automatic test_full_list();
        int k;
        wait_drained();
        for (k = 0; k < DEPTH; k++) begin
            if (k % 3 == 0 && k != DEPTH - 1)
                send_request(bdws_pkg::OP_PUSH_FRONT, 32'h1000_0000 | k);
            else
                send_request(bdws_pkg::OP_PUSH_BACK, 32'h1000_0000 | k);
        end
        send_request(bdws_pkg::OP_PUSH_BACK, 32'hDEAD_BEEF);
        send_request(bdws_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
        send_request(bdws_pkg::OP_FIND, 32'h1000_0000 | (DEPTH - 1));
        send_request(bdws_pkg::OP_FIND, 32'h1000_0000);
        send_request(bdws_pkg::OP_FIND, 32'hDEAD_BEEF);
        send_request(bdws_pkg::OP_FIND, stored_word());
        k = 0;
        while (model_len > 0) begin
            send_request(k[0] ? bdws_pkg::OP_POP_BACK : bdws_pkg::OP_POP_FRONT, $urandom);
            if (model_len % 16 == 0)
                send_request(bdws_pkg::OP_FIND, stored_word());
            k++;
        end
        send_request(bdws_pkg::OP_POP_BACK, $urandom);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        t_traffic_mode mode;
        int n;
        int r;
        int push_w;
        int pop_w;
        logic [bdws_pkg::OP_BITS-1:0] op;
        logic [bdws_pkg::VALUE_BITS-1:0] val;
        mode = MODE_MIXED;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 40 == 0) begin
                r = $urandom_range(0, 2);
                mode = (r == 0) ? MODE_GROW : (r == 1) ? MODE_SHRINK : MODE_MIXED;
                sender_quiet = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0)
                    wait_drained();
            end
            case (mode)
                MODE_GROW:   begin push_w = 55; pop_w = 20; end
                MODE_SHRINK: begin push_w = 20; pop_w = 55; end
                default:     begin push_w = 38; pop_w = 37; end
            endcase
            r = $urandom_range(0, 99);
            if (r < push_w) begin
                op  = r[0] ? bdws_pkg::OP_PUSH_FRONT : bdws_pkg::OP_PUSH_BACK;
                val = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
            end else if (r < push_w + pop_w) begin
                op  = r[0] ? bdws_pkg::OP_POP_FRONT : bdws_pkg::OP_POP_BACK;
                val = $urandom;
            end else if (r < 97) begin
                op = bdws_pkg::OP_FIND;
                case ($urandom_range(0, 4))
                    0, 1, 2: val = stored_word();
                    3:       val = value_pool[$urandom_range(0, 7)];
                    default: val = $urandom;
                endcase
            end else begin
                op  = bdws_pkg::OP_BITS'($urandom_range(OP_SPARE_A, OP_SPARE_C));
                val = $urandom;
            end
            send_request(op, val);
        end
        sender_quiet = 1'b0;
    endtask

    initial begin
        int k;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= bdws_pkg::OP_PUSH_BACK;
        i_value     <= '0;
        i_stall     <= 1'b0;
        model_len     = 0;
        fail_count    = 0;
        results_seen  = 0;
        requests_sent = 0;
        find_hits     = 0;
        find_misses   = 0;
        full_rejects  = 0;
        empty_rejects = 0;
        spare_ops     = 0;
        sender_quiet  = 1'b0;
        sink_quiet    = 1'b0;
        sink_mode_left = 0;
        stall_left    = 0;
        for (k = 0; k < DEPTH; k++)
            model_words[k] = '0;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (k = 2; k < 8; k++)
            value_pool[k] = $urandom;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_basic_operations();
        test_full_list();
        test_random_traffic();

        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("covered %0d requests, %0d results: %0d find hits, %0d find misses",
                 requests_sent, results_seen, find_hits, find_misses);
        $display("rejected pushes when full %0d, pops when empty %0d, spare codes %0d",
                 full_rejects, empty_rejects, spare_ops);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb_bounded_deque_with_search_core passed");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count,
                     expected_results.size());
            $display("tb_bounded_deque_with_search_core failed");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 800_000);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("tb_bounded_deque_with_search_core failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/bdws_pkg.sv
hw/rtl/bdws_cell.sv
hw/rtl/bounded_deque_with_search_core.sv
bench/tb_bounded_deque_with_search_core.sv
